@@ design/fac_pkg.sv @@
// Shared types and constants of the frustum box culling unit.
`timescale 1ns / 1ps

package fac_pkg;

    // Item kinds on the input channel
    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_BOX  = 1'b1
    } t_kind;

    localparam int FIELD_W     = 32;  // width of matrix entries and box fields
    localparam int COEF_W      = 33;  // exact sum or difference of two entries
    localparam int FRAC_W      = 16;  // Q16.16 fraction bits
    localparam int NUM_ENTRIES = 16;
    localparam int NUM_PLANES  = 6;
    localparam int NUM_COEF    = 4;   // a, b, c, d
    localparam int NUM_AXES    = 3;
    localparam int ROW_LEN     = 4;
    localparam int W_ROW       = 3;   // row that every plane adds to

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [FIELD_W-1:0] t_entry;

endpackage

@@ design/frustum_aabb_cull_unit.sv @@
// Frustum culling of axis-aligned boxes against a stored view-projection matrix.
//
// Usage:
//   Input channel (i_valid / o_stall): a transfer with i_kind = load writes
//   i_entry_value into matrix entry i_entry_index (row*4+column) and returns
//   nothing. A transfer with i_kind = box tests the box given by i_min_* and
//   i_max_* against the six planes row3 +/- row0..2 and returns one result.
//   Output channel (o_valid / i_stall): o_visible is 1 unless the box lies
//   wholly on the outer side of some plane (distance exactly zero is inside).
//   A box passes through the box register, the product register and the
//   result register in that order, and its result can transfer out once it
//   is in the result register. Throughput is one item per cycle while the
//   receiver does not stall, set by the three-stage pipeline with one
//   multiplier per plane and axis. A load takes effect for the very next box.
//   Reset clears the matrix (all zero), the plane registers and every valid
//   bit. When the receiver stalls, the result register holds; earlier stages
//   keep advancing into empty slots, and o_stall rises only once every stage
//   holds an item.
`timescale 1ns / 1ps

module frustum_aabb_cull_unit #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_kind,
    input  logic [3:0]                         i_entry_index,
    input  logic signed [fac_pkg::FIELD_W-1:0] i_entry_value,
    input  logic signed [fac_pkg::FIELD_W-1:0] i_min_x,
    input  logic signed [fac_pkg::FIELD_W-1:0] i_min_y,
    input  logic signed [fac_pkg::FIELD_W-1:0] i_min_z,
    input  logic signed [fac_pkg::FIELD_W-1:0] i_max_x,
    input  logic signed [fac_pkg::FIELD_W-1:0] i_max_y,
    input  logic signed [fac_pkg::FIELD_W-1:0] i_max_z,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_visible
);

    // Effective coordinate width: fields above bit 31 do not exist
    localparam int CW = (COORD_WIDTH < fac_pkg::FIELD_W) ? COORD_WIDTH : fac_pkg::FIELD_W;
    localparam int PW = fac_pkg::COEF_W + CW;  // exact product width
    localparam int SW = PW + 2;                // three products plus scaled d

    // Matrix store and planes derived from it
    fac_pkg::t_entry r_mat [fac_pkg::NUM_ENTRIES];
    fac_pkg::t_coef  r_plane [fac_pkg::NUM_PLANES][fac_pkg::NUM_COEF];
    fac_pkg::t_coef  n_plane [fac_pkg::NUM_PLANES][fac_pkg::NUM_COEF];

    // Stage A: box registers
    logic                r_a_valid;
    logic signed [CW-1:0] r_a_min [fac_pkg::NUM_AXES];
    logic signed [CW-1:0] r_a_max [fac_pkg::NUM_AXES];

    // Stage B: products and plane offsets
    logic                 r_b_valid;
    logic signed [PW-1:0] r_b_prod [fac_pkg::NUM_PLANES][fac_pkg::NUM_AXES];
    logic signed [PW-1:0] n_b_prod [fac_pkg::NUM_PLANES][fac_pkg::NUM_AXES];
    fac_pkg::t_coef       r_b_d [fac_pkg::NUM_PLANES];

    // Stage C: result register
    logic                 r_c_valid;
    logic                 r_c_vis;
    logic                 n_c_vis;
    logic signed [SW-1:0] plane_dist [fac_pkg::NUM_PLANES];

    // Stage enables: a stage advances when it is empty or the next one advances
    logic en_a, en_b, en_c;
    logic in_xfer;

    assign en_c    = !r_c_valid || !i_stall;
    assign en_b    = !r_b_valid || en_c;
    assign en_a    = !r_a_valid || en_b;
    assign o_stall = !en_a;
    assign in_xfer = i_valid && en_a;

    assign o_valid   = r_c_valid;
    assign o_visible = r_c_vis;

    // Plane coefficients: row 3 plus (even planes) or minus (odd planes) row p/2
    always_comb begin
        for (int p = 0; p < fac_pkg::NUM_PLANES; p++) begin
            for (int k = 0; k < fac_pkg::NUM_COEF; k++) begin
                if ((p & 1) != 0) begin
                    n_plane[p][k] =
                        fac_pkg::t_coef'(r_mat[fac_pkg::W_ROW * fac_pkg::ROW_LEN + k])
                      - fac_pkg::t_coef'(r_mat[(p >> 1) * fac_pkg::ROW_LEN + k]);
                end else begin
                    n_plane[p][k] =
                        fac_pkg::t_coef'(r_mat[fac_pkg::W_ROW * fac_pkg::ROW_LEN + k])
                      + fac_pkg::t_coef'(r_mat[(p >> 1) * fac_pkg::ROW_LEN + k]);
                end
            end
        end
    end

    // Matrix store: write at the load transfer; the plane registers follow at the next
    // edge, which is the earliest edge a following box can enter stage A.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < fac_pkg::NUM_ENTRIES; e++) begin
                r_mat[e] <= '0;
            end
            for (int p = 0; p < fac_pkg::NUM_PLANES; p++) begin
                for (int k = 0; k < fac_pkg::NUM_COEF; k++) begin
                    r_plane[p][k] <= '0;
                end
            end
        end else begin
            if (in_xfer && i_kind == fac_pkg::KIND_LOAD) begin
                r_mat[i_entry_index] <= i_entry_value;
            end
            r_plane <= n_plane;
        end
    end

    // Stage A: capture the box; loads never enter the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en_a) begin
            r_a_valid <= in_xfer && i_kind == fac_pkg::KIND_BOX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_min[0] <= i_min_x[CW-1:0];
            r_a_min[1] <= i_min_y[CW-1:0];
            r_a_min[2] <= i_min_z[CW-1:0];
            r_a_max[0] <= i_max_x[CW-1:0];
            r_a_max[1] <= i_max_y[CW-1:0];
            r_a_max[2] <= i_max_z[CW-1:0];
        end
    end

    // Stage A to B: pick the corner farthest along each normal and multiply
    always_comb begin
        for (int p = 0; p < fac_pkg::NUM_PLANES; p++) begin
            for (int k = 0; k < fac_pkg::NUM_AXES; k++) begin
                if (r_plane[p][k][fac_pkg::COEF_W-1]) begin
                    n_b_prod[p][k] = PW'(r_plane[p][k]) * PW'(r_a_min[k]);
                end else begin
                    n_b_prod[p][k] = PW'(r_plane[p][k]) * PW'(r_a_max[k]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_b_prod <= n_b_prod;
            for (int p = 0; p < fac_pkg::NUM_PLANES; p++) begin
                r_b_d[p] <= r_plane[p][fac_pkg::NUM_COEF-1];
            end
        end
    end

    // Stage B to C: exact distance in Q35.32 (at COORD_WIDTH 32), culled if any is negative
    always_comb begin
        n_c_vis = 1'b1;
        for (int p = 0; p < fac_pkg::NUM_PLANES; p++) begin
            plane_dist[p] = SW'(r_b_prod[p][0]) + SW'(r_b_prod[p][1])
                          + SW'(r_b_prod[p][2])
                          + (SW'(r_b_d[p]) <<< fac_pkg::FRAC_W);
            n_c_vis = n_c_vis && !plane_dist[p][SW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en_c) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_c) begin
            r_c_vis <= n_c_vis;
        end
    end

    // Load transfers leave no item in the pipeline
    a_load_no_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_kind == fac_pkg::KIND_LOAD) |=> !r_a_valid)
        else $error("load transfer entered the pipeline");

    // Input stalls only when every stage is full and the output is blocked
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_a_valid && r_b_valid && r_c_valid && i_stall))
        else $error("input stalled with room in the pipeline");

    // An item advancing out of stage A lands in stage B
    a_a_to_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && en_b) |=> r_b_valid)
        else $error("item lost between stage A and B");

    // An item advancing out of stage B reaches the output
    a_b_to_c: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && en_c) |=> o_valid)
        else $error("item lost between stage B and output");

endmodule
